// ===== rtl/core/hnp_pkg.sv =====
package hnp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CODE_W    = 16;
    localparam int RANGE_W   = 16;
    localparam int TEXEL_W   = 12;
    localparam int PROD_W    = CODE_W + RANGE_W;
    localparam int VW        = PROD_W + 1;
    localparam int MAGW      = VW - 1;
    localparam int MW        = 30;
    localparam int SW        = 64;
    localparam int SQ_STEPS  = SW / 2;
    localparam int RW        = MW + 2;
    localparam int QW        = FRAC_BITS + 1;
    localparam int UW        = FRAC_BITS + 2;
    localparam int SHW       = 5;
    localparam int PACK_W    = UW + 7;

    localparam logic [CODE_W-1:0] CODE_MAX   = '1;
    localparam logic [6:0]        PACK_SCALE = 7'd127;

    localparam logic CFG_HEIGHT_RANGE = 1'b0;
    localparam logic CFG_TEXEL_SIZE   = 1'b1;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 16'd10000;
    localparam logic [TEXEL_W-1:0] TEXEL_RESET = 12'd100;

    typedef struct packed {
        logic [CODE_W-1:0] height_center;
        logic [CODE_W-1:0] height_left;
        logic [CODE_W-1:0] height_right;
        logic [CODE_W-1:0] height_below;
        logic [CODE_W-1:0] height_above;
        logic              left_valid;
        logic              right_valid;
        logic              below_valid;
        logic              above_valid;
    } t_in;

    typedef struct packed {
        logic [7:0] normal_x_byte;
        logic [7:0] normal_y_byte;
        logic [7:0] normal_z_byte;
    } t_out;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [UW-1:0] x;
        logic signed [UW-1:0] y;
        logic signed [UW-1:0] z;
    } t_unit;

    typedef struct packed {
        logic       valid;
        logic       nz;
        logic [2:0] neg;
    } t_side;

endpackage

// ===== rtl/core/hnp_scale.sv =====
module hnp_scale import hnp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_in                  i_data,
    input  logic [RANGE_W-1:0]   i_range,
    input  logic [TEXEL_W-1:0]   i_texel,
    output logic                 o_valid,
    output t_vec [3:0]           o_vec
);

    logic [4:0][CODE_W-1:0] code;
    logic [4:0][PROD_W-1:0] r_p;
    logic [4:0][PROD_W-1:0] n_h;
    logic [4:0][PROD_W-1:0] r_h;
    logic [3:0]             n_tri;
    logic [3:0]             r_tri1;
    logic [3:0]             r_tri2;
    logic                   r_v1;
    logic                   r_v2;
    logic                   r_v3;
    t_vec [3:0]             n_vec;
    t_vec [3:0]             r_vec;

    assign code = {i_data.height_above, i_data.height_below, i_data.height_right,
                   i_data.height_left, i_data.height_center};

    assign n_tri = {i_data.left_valid  & i_data.above_valid,
                    i_data.right_valid & i_data.above_valid,
                    i_data.right_valid & i_data.below_valid,
                    i_data.left_valid  & i_data.below_valid};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 5; i++) begin
                r_p[i] <= PROD_W'(code[i]) * PROD_W'(i_range);
            end
            r_tri1 <= n_tri;
        end
    end

    // Dividing by 65535 after a 16-bit left shift is p + floor(p / 65535).
    always_comb begin
        logic [CODE_W-1:0] q;
        logic [CODE_W:0]   rr;
        logic [CODE_W:0]   qc;
        for (int i = 0; i < 5; i++) begin
            q      = r_p[i][PROD_W-1:CODE_W];
            rr     = (CODE_W+1)'(r_p[i][CODE_W-1:0]) + (CODE_W+1)'(q);
            qc     = (CODE_W+1)'(q) + (CODE_W+1)'(rr >= (CODE_W+1)'(CODE_MAX));
            n_h[i] = r_p[i] + PROD_W'(qc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h    <= n_h;
            r_tri2 <= r_tri1;
        end
    end

    always_comb begin
        logic signed [VW-1:0] hc;
        logic signed [VW-1:0] dl;
        logic signed [VW-1:0] ndr;
        logic signed [VW-1:0] db;
        logic signed [VW-1:0] nda;
        logic signed [VW-1:0] tex;
        logic                 tex_nz;
        hc     = $signed({1'b0, r_h[0]});
        dl     = $signed({1'b0, r_h[1]}) - hc;
        ndr    = hc - $signed({1'b0, r_h[2]});
        db     = $signed({1'b0, r_h[3]}) - hc;
        nda    = hc - $signed({1'b0, r_h[4]});
        tex    = $signed(VW'(i_texel) << FRAC_BITS);
        tex_nz = (i_texel != '0);
        n_vec[0] = '{x: dl,  y: db,  z: tex};
        n_vec[1] = '{x: ndr, y: db,  z: tex};
        n_vec[2] = '{x: ndr, y: nda, z: tex};
        n_vec[3] = '{x: dl,  y: nda, z: tex};
        for (int t = 0; t < 4; t++) begin
            if (!(r_tri2[t] && tex_nz)) begin
                n_vec[t] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_vec   = r_vec;

endmodule

// ===== rtl/core/hnp_unitize.sv =====
module hnp_unitize import hnp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_vec  i_vec,
    output logic  o_valid,
    output logic  o_ok,
    output t_unit o_unit
);

    logic [2:0][VW-1:0]    comp;
    logic [2:0][MAGW-1:0]  n_a_mag;
    logic [2:0]            n_a_neg;
    logic [MAGW-1:0]       n_a_max;
    logic [2:0][MAGW-1:0]  r_a_mag;
    logic [MAGW-1:0]       r_a_max;
    t_side                 r_a_side;

    logic [SHW-1:0]        n_b_sh;
    logic                  n_b_right;
    logic                  n_b_nz;
    logic [2:0][MAGW-1:0]  r_b_mag;
    logic [SHW-1:0]        r_b_sh;
    logic                  r_b_right;
    t_side                 r_b_side;

    logic [2:0][MW-1:0]    n_c_mag;
    logic [2:0][MW-1:0]    r_c_mag;
    t_side                 r_c_side;

    logic [2:0][2*MW-1:0]  r_d_sq;
    logic [2:0][MW-1:0]    r_d_mag;
    t_side                 r_d_side;

    logic [SW-1:0]         n_s   [0:SQ_STEPS];
    logic [SW-1:0]         n_res [0:SQ_STEPS];
    logic [SW-1:0]         r_s   [0:SQ_STEPS];
    logic [SW-1:0]         r_res [0:SQ_STEPS];
    logic [2:0][MW-1:0]    r_sq_mag  [0:SQ_STEPS];
    t_side                 r_sq_side [0:SQ_STEPS];

    logic [2:0][RW-1:0]    n_rem  [0:QW-1];
    logic [2:0][QW-1:0]    n_quo  [0:QW-1];
    logic [RW-1:0]         n_root [0:QW-1];
    logic [2:0][RW-1:0]    r_rem  [0:QW-1];
    logic [2:0][QW-1:0]    r_quo  [0:QW-1];
    logic [RW-1:0]         r_root [0:QW-1];
    t_side                 r_dv_side [0:QW-1];

    t_unit                 n_unit;
    t_unit                 r_unit;
    t_side                 r_o_side;

    assign comp = {i_vec.x, i_vec.y, i_vec.z};

    always_comb begin
        n_a_max = '0;
        for (int i = 0; i < 3; i++) begin
            n_a_neg[i] = comp[i][VW-1];
            n_a_mag[i] = n_a_neg[i] ? MAGW'(-$signed(comp[i])) : MAGW'(comp[i]);
            if (n_a_mag[i] > n_a_max) begin
                n_a_max = n_a_mag[i];
            end
        end
    end

    // Bring the largest magnitude into [2^29, 2^30) with one shift.
    always_comb begin
        logic [SHW-1:0] msb;
        msb = '0;
        for (int i = 0; i < MAGW; i++) begin
            if (r_a_max[i]) begin
                msb = SHW'(i);
            end
        end
        n_b_nz    = (r_a_max != '0);
        n_b_right = (msb > SHW'(MW - 1));
        n_b_sh    = n_b_right ? msb - SHW'(MW - 1) : SHW'(MW - 1) - msb;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c_mag[i] = r_b_right ? MW'(r_b_mag[i] >> r_b_sh) : MW'(r_b_mag[i] << r_b_sh);
        end
    end

    always_comb begin
        logic [SW-1:0] bitv;
        logic [SW-1:0] trial;
        n_s[0]   = SW'(r_d_sq[0]) + SW'(r_d_sq[1]) + SW'(r_d_sq[2]);
        n_res[0] = '0;
        for (int k = 0; k < SQ_STEPS; k++) begin
            bitv  = SW'(1) << (2 * (SQ_STEPS - 1 - k));
            trial = r_res[k] + bitv;
            if (r_s[k] >= trial) begin
                n_s[k+1]   = r_s[k] - trial;
                n_res[k+1] = (r_res[k] >> 1) + bitv;
            end else begin
                n_s[k+1]   = r_s[k];
                n_res[k+1] = r_res[k] >> 1;
            end
        end
    end

    always_comb begin
        logic [RW-1:0] rin;
        logic [QW-1:0] qin;
        logic [RW-1:0] trial;
        for (int j = 0; j < QW; j++) begin
            n_root[j] = (j == 0) ? r_res[SQ_STEPS][RW-1:0] : r_root[j-1];
            for (int i = 0; i < 3; i++) begin
                rin   = (j == 0) ? RW'(r_sq_mag[SQ_STEPS][i]) : r_rem[j-1][i];
                qin   = (j == 0) ? '0 : r_quo[j-1][i];
                trial = (j == 0) ? rin : {rin[RW-2:0], 1'b0};
                if (trial >= n_root[j]) begin
                    n_rem[j][i] = trial - n_root[j];
                    n_quo[j][i] = {qin[QW-2:0], 1'b1};
                end else begin
                    n_rem[j][i] = trial;
                    n_quo[j][i] = {qin[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic signed [UW-1:0] q [3];
        for (int i = 0; i < 3; i++) begin
            q[i] = $signed(UW'(r_quo[QW-1][i]));
            if (r_dv_side[QW-1].neg[i]) begin
                q[i] = -q[i];
            end
        end
        n_unit = '{x: q[2], y: q[1], z: q[0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag   <= n_a_mag;
            r_a_max   <= n_a_max;
            r_b_mag   <= r_a_mag;
            r_b_sh    <= n_b_sh;
            r_b_right <= n_b_right;
            r_c_mag   <= n_c_mag;
            for (int i = 0; i < 3; i++) begin
                r_d_sq[i] <= (2*MW)'(r_c_mag[i]) * (2*MW)'(r_c_mag[i]);
            end
            r_d_mag <= r_c_mag;
            for (int k = 0; k <= SQ_STEPS; k++) begin
                r_s[k]   <= n_s[k];
                r_res[k] <= n_res[k];
                r_sq_mag[k] <= (k == 0) ? r_d_mag : r_sq_mag[k-1];
            end
            for (int j = 0; j < QW; j++) begin
                r_rem[j]  <= n_rem[j];
                r_quo[j]  <= n_quo[j];
                r_root[j] <= n_root[j];
            end
            r_unit <= n_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
            r_b_side <= '0;
            r_c_side <= '0;
            r_d_side <= '0;
            for (int k = 0; k <= SQ_STEPS; k++) begin
                r_sq_side[k] <= '0;
            end
            for (int j = 0; j < QW; j++) begin
                r_dv_side[j] <= '0;
            end
            r_o_side <= '0;
        end else if (i_en) begin
            r_a_side <= '{valid: i_valid, nz: 1'b0, neg: n_a_neg};
            r_b_side <= '{valid: r_a_side.valid, nz: n_b_nz, neg: r_a_side.neg};
            r_c_side <= r_b_side;
            r_d_side <= r_c_side;
            for (int k = 0; k <= SQ_STEPS; k++) begin
                r_sq_side[k] <= (k == 0) ? r_d_side : r_sq_side[k-1];
            end
            for (int j = 0; j < QW; j++) begin
                r_dv_side[j] <= (j == 0) ? r_sq_side[SQ_STEPS] : r_dv_side[j-1];
            end
            r_o_side <= r_dv_side[QW-1];
        end
    end

    assign o_valid = r_o_side.valid;
    assign o_ok    = r_o_side.nz;
    assign o_unit  = r_unit;

endmodule

// ===== rtl/core/heightmap_normal_pack.sv =====
// Computes the packed surface normal of one heightmap pixel per beat. A new beat
// can be taken every clock while the output is not stalled; each beat passes
// through height scaling, two normalizing pipelines in turn (each with a 32-step
// square root and a 17-step divide), the triangle sum and byte packing.
// The whole pipeline holds while a finished beat waits on the output.
// Register 0 is the height range in centimeters and register 1 the texel size;
// write them only while no beat is in flight.
module heightmap_normal_pack import hnp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in                 i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out                o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [RANGE_W-1:0]  i_cfg_data
);

    logic [RANGE_W-1:0] r_range;
    logic [TEXEL_W-1:0] r_texel;
    logic               en;
    logic               sc_valid;
    t_vec [3:0]         sc_vec;
    logic [3:0]         tri_valid;
    logic [3:0]         tri_ok;
    t_unit [3:0]        tri_unit;
    t_vec               n_sum;
    t_vec               r_sum;
    logic               r_sum_valid;
    logic               fin_valid;
    logic               fin_ok;
    t_unit              fin_unit;
    t_out               n_out;
    t_out               r_out;
    logic               r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= RANGE_RESET;
            r_texel <= TEXEL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEIGHT_RANGE: r_range <= i_cfg_data;
                CFG_TEXEL_SIZE:   r_texel <= i_cfg_data[TEXEL_W-1:0];
                default:          r_range <= r_range;
            endcase
        end
    end

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    hnp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_range (r_range),
        .i_texel (r_texel),
        .o_valid (sc_valid),
        .o_vec   (sc_vec)
    );

    for (genvar t = 0; t < 4; t++) begin : g_tri
        hnp_unitize u_tri (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sc_valid),
            .i_vec   (sc_vec[t]),
            .o_valid (tri_valid[t]),
            .o_ok    (tri_ok[t]),
            .o_unit  (tri_unit[t])
        );
    end

    always_comb begin
        n_sum.x = '0;
        n_sum.y = '0;
        n_sum.z = $signed(VW'(1) << FRAC_BITS);
        for (int t = 0; t < 4; t++) begin
            if (tri_ok[t]) begin
                n_sum.x = n_sum.x + VW'(tri_unit[t].x);
                n_sum.y = n_sum.y + VW'(tri_unit[t].y);
                n_sum.z = n_sum.z + VW'(tri_unit[t].z);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (en) begin
            r_sum_valid <= &tri_valid;
        end
    end

    hnp_unitize u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sum_valid),
        .i_vec   (r_sum),
        .o_valid (fin_valid),
        .o_ok    (fin_ok),
        .o_unit  (fin_unit)
    );

    always_comb begin
        logic [2:0][UW-1:0]     biased;
        logic [2:0][PACK_W-1:0] prod;
        logic [2:0][7:0]        pb;
        biased[0] = UW'(fin_unit.x) + (UW'(1) << FRAC_BITS);
        biased[1] = UW'(fin_unit.y) + (UW'(1) << FRAC_BITS);
        biased[2] = UW'(fin_unit.z) + (UW'(1) << FRAC_BITS);
        for (int i = 0; i < 3; i++) begin
            prod[i] = PACK_W'(biased[i]) * PACK_W'(PACK_SCALE);
            pb[i]   = prod[i][FRAC_BITS+7:FRAC_BITS];
        end
        n_out = '{normal_x_byte: pb[0], normal_y_byte: pb[1], normal_z_byte: pb[2]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fin_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_sum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_valid |-> fin_ok)
        else $error("final sum reached the normalizer as a zero vector");

    a_z_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.normal_z_byte >= 8'd127)
        else $error("packed normal points below the surface");

    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.normal_x_byte <= 8'd254) &&
                        (o_out_data.normal_y_byte <= 8'd254) &&
                        (o_out_data.normal_z_byte <= 8'd254))
        else $error("packed component exceeds unit length");

endmodule

// ===== sim/tb_heightmap_normal_pack.sv =====
module tb_heightmap_normal_pack;
    import hnp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = 115;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 212;

    typedef struct {
        t_in  beat;
        bit   known;
        t_out want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = CFG_HEIGHT_RANGE;
    logic [RANGE_W-1:0] i_cfg_data = '0;

    longint unsigned range_cm = RANGE_RESET;
    longint unsigned texel_cm = TEXEL_RESET;
    t_out normals_due[$];
    int errors = 0;
    bit calm = 1'b0;
    bit squeeze_req = 1'b0;
    bit squeeze_seen = 1'b0;

    heightmap_normal_pack dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("heightmap_normal_pack regression: fail");
        $finish;
    end

    function automatic longint unsigned floor_root(longint unsigned s);
        longint unsigned res;
        longint unsigned bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > s) bit_w >>= 2;
        while (bit_w != 0) begin
            if (s >= res + bit_w) begin
                s -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function automatic bit make_unit(input longint v[3], output longint u[3]);
        longint unsigned mag[3];
        bit neg[3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned r;
        longint unsigned q;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m) m = mag[i];
            u[i] = 0;
        end
        if (m == 0) return 1'b0;
        while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
            m <<= 1;
        end
        for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
        r = floor_root(s);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] << FRAC_BITS) / r;
            u[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic longint height_cm(logic [CODE_W-1:0] code);
        longint unsigned p;
        p = (longint'(code) * range_cm) << FRAC_BITS;
        return longint'(p / 64'd65535);
    endfunction

    function automatic logic [7:0] to_byte(longint c);
        longint unsigned biased;
        biased = longint'(c + (64'sd1 << FRAC_BITS));
        return 8'((biased * 64'd127) >> FRAC_BITS);
    endfunction

    function automatic t_out surface_normal(t_in b);
        longint hc, dl, dr, db, da, t;
        longint acc[3];
        longint v[3];
        longint u[3];
        longint n[3];
        bit use_tri[4];
        t_out o;
        hc = height_cm(b.height_center);
        dl = height_cm(b.height_left) - hc;
        dr = height_cm(b.height_right) - hc;
        db = height_cm(b.height_below) - hc;
        da = height_cm(b.height_above) - hc;
        t = longint'(texel_cm << FRAC_BITS);
        acc = '{0, 0, 64'sd1 << FRAC_BITS};
        use_tri = '{b.left_valid && b.below_valid, b.right_valid && b.below_valid,
                    b.right_valid && b.above_valid, b.left_valid && b.above_valid};
        if (texel_cm != 0) begin
            for (int k = 0; k < 4; k++) begin
                if (use_tri[k]) begin
                    v[0] = (k == 0 || k == 3) ? dl : -dr;
                    v[1] = (k < 2) ? db : -da;
                    v[2] = t;
                    if (make_unit(v, u)) begin
                        for (int i = 0; i < 3; i++) acc[i] += u[i];
                    end
                end
            end
        end
        if (!make_unit(acc, n)) n = '{0, 0, 64'sd1 << FRAC_BITS};
        o.normal_x_byte = to_byte(n[0]);
        o.normal_y_byte = to_byte(n[1]);
        o.normal_z_byte = to_byte(n[2]);
        return o;
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (normals_due.size() == 0) begin
                report("unexpected beat", o_out_data.normal_x_byte, 8'd0);
            end else begin
                want = normals_due.pop_front();
                if (o_out_data.normal_x_byte !== want.normal_x_byte)
                    report("normal_x_byte", o_out_data.normal_x_byte, want.normal_x_byte);
                if (o_out_data.normal_y_byte !== want.normal_y_byte)
                    report("normal_y_byte", o_out_data.normal_y_byte, want.normal_y_byte);
                if (o_out_data.normal_z_byte !== want.normal_z_byte)
                    report("normal_z_byte", o_out_data.normal_z_byte, want.normal_z_byte);
            end
        end
    end

    always @(posedge i_clk) begin
        int hold;
        logic rdy;
        if (!i_rst_n) begin
            hold = 0;
        end
        if (squeeze_req && !squeeze_seen) begin
            squeeze_seen = 1'b1;
            hold = SQUEEZE_CYCLES;
        end
        if (hold > 0) begin
            hold--;
            rdy = 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 13) - 1;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        i_out_ready <= rdy;
    end

    task automatic write_reg(logic idx, logic [RANGE_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEIGHT_RANGE) range_cm = val;
        else texel_cm = val & 16'h0FFF;
    endtask

    task automatic send_pixel(t_in b, bit known, t_out want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (!o_in_ready);
        normals_due.push_back(known ? want : surface_normal(b));
    endtask

    function automatic logic [CODE_W-1:0] near_code(logic [CODE_W-1:0] c);
        int x;
        x = int'(c) + $urandom_range(0, 600) - 300;
        return (x < 0) ? '0 : (x > 65535) ? CODE_MAX : CODE_W'(x);
    endfunction

    function automatic logic [CODE_W-1:0] any_code(int kind);
        case (kind)
            0: return '0;
            1: return CODE_MAX;
            default: return CODE_W'($urandom);
        endcase
    endfunction

    function automatic t_in random_pixel();
        t_in b;
        int kind;
        kind = $urandom_range(0, 9);
        b.height_center = any_code($urandom_range(0, 15));
        if (kind < 6) begin
            b.height_left = near_code(b.height_center);
            b.height_right = near_code(b.height_center);
            b.height_below = near_code(b.height_center);
            b.height_above = near_code(b.height_center);
        end else begin
            b.height_left = any_code($urandom_range(0, 7));
            b.height_right = any_code($urandom_range(0, 7));
            b.height_below = any_code($urandom_range(0, 7));
            b.height_above = any_code($urandom_range(0, 7));
        end
        {b.left_valid, b.right_valid, b.below_valid, b.above_valid} = 4'($urandom);
        return b;
    endfunction

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (normals_due.size() == 0);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    initial begin
        t_row rows[$];
        t_out flat;
        t_out none;
        logic [RANGE_W-1:0] ranges[6];
        logic [RANGE_W-1:0] texels[6];
        flat = '{8'd127, 8'd127, 8'd254};
        none = '0;
        rows.push_back('{'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 1'b0},
                         1'b1, flat});
        rows.push_back('{'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 1'b1, 1'b1, 1'b1},
                         1'b1, flat});
        rows.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, flat});
        rows.push_back('{'{16'h1234, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF,
                           1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, flat});
        rows.push_back('{'{16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, none});
        rows.push_back('{'{16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0,
                           1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, none});
        rows.push_back('{'{16'h8000, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF,
                           1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, none});
        rows.push_back('{'{16'h8000, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF,
                           1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, none});
        rows.push_back('{'{16'h8000, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF,
                           1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, none});
        rows.push_back('{'{16'h8000, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF,
                           1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, none});
        rows.push_back('{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                           1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, none});
        rows.push_back('{'{16'h4000, 16'h4001, 16'h3FFF, 16'h4000, 16'h4000,
                           1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, none});
        ranges = '{16'd65535, 16'd1, 16'd0, 16'd12345, 16'd65535, 16'd10000};
        texels = '{12'd1, 12'd4095, 12'd100, 12'd0, 12'd4095, 12'd37};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) send_pixel(rows[r].beat, rows[r].known, rows[r].want);
        for (int n = 0; n < ITEMS_PER_PHASE; n++) send_pixel(random_pixel(), 1'b0, none);

        for (int p = 0; p < 6; p++) begin
            settle();
            write_reg(CFG_HEIGHT_RANGE, ranges[p]);
            write_reg(CFG_TEXEL_SIZE, texels[p]);
            if (p == 1) squeeze_req = 1'b1;
            if (p == 5) calm = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_pixel(random_pixel(), 1'b0, none);
        end

        settle();
        if (errors == 0) begin
            $display("heightmap_normal_pack regression: pass");
        end else begin
            $display("heightmap_normal_pack regression: fail");
        end
        $finish;
    end
endmodule
